FILE: hdl/mbps_pkg.sv
// shared types and codes for the masked byte pattern search
package mbps_pkg;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_SCAN = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_USE_MASK       = 2'd1,
    REG_FIND_LAST      = 2'd2,
    REG_WINDOW_BASE    = 2'd3
  } reg_index_t;

  localparam int CFG_DATA_W = 32;
  localparam int OFFSET_W   = 32;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic       scan;
    logic       window_end;
    logic       use_mask;
    logic [7:0] data_byte;
  } cell_ctrl_t;

endpackage

FILE: hdl/mbps_if.sv
// valid/ready channels for load and scan commands and search results
interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [6:0] entry_index;
  logic [7:0] pattern_value;
  logic [7:0] mask_value;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (
    output valid, command, entry_index, pattern_value, mask_value, data_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, pattern_value, mask_value, data_byte, last_byte,
    output ready
  );
endinterface

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink (input valid, found, match_address, output ready);
endinterface

FILE: hdl/masked_byte_pattern_search.sv
// top level of the masked byte pattern search
//
// Usage: load pattern and mask entries with command items (command = load,
// entry_index, pattern_value, mask_value); an index beyond the chain is
// dropped. Then stream the window's bytes as scan items, lowest address
// first, with last_byte set on the final one. Configuration registers are
// written through cfg_write/cfg_index/cfg_data while no item is in flight.
// A row of MAX_PATTERN_BYTES cells holds the pattern; every cell compares
// the incoming byte and hands its alive bit to its neighbour, so all
// alignments are tracked together and one scan byte is taken per cycle.
// The result item (found, match_address = window_base + match offset, or
// zero when nothing matched) is offered on the output channel once the
// last byte has passed the cell stage registers and then the output
// register through the match selection.
// Reset clears the alive bits, the position and match state and sets the
// registers to length one, whole-byte compare, first match, base zero.
// Pattern entries hold no reset value and must be loaded before use.
// While a result waits unaccepted the input ready drops and the whole
// pipeline holds.
module masked_byte_pattern_search #(
  parameter int MAX_PATTERN_BYTES = 128,
  parameter int ADDRESS_WIDTH     = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data,
  mbps_in_if.sink                           in_ch,
  mbps_out_if.source                        out_ch
);

  localparam int IDX_W     = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int MASK_BITS = (ADDRESS_WIDTH < 32) ? ADDRESS_WIDTH : 32;
  localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFF >> (32 - MASK_BITS);

  // configuration
  logic [IDX_W-1:0] tail;
  logic             use_mask;
  logic             find_last;
  logic [31:0]      window_base;

  // scan tracking
  logic [mbps_pkg::OFFSET_W-1:0] byte_position;
  logic                          st_valid;
  logic                          st_last;
  logic                          st_hit;
  logic [mbps_pkg::OFFSET_W-1:0] st_start;
  logic                          seen;
  logic [mbps_pkg::OFFSET_W-1:0] offset;
  logic                          out_valid_q;
  logic                          out_found_q;
  logic [31:0]                   out_addr_q;

  logic                          advance;
  logic                          in_acc;
  logic                          scan_acc;
  logic                          load_acc;
  mbps_pkg::cell_ctrl_t          ctrl;
  logic [MAX_PATTERN_BYTES-1:0]  chain;
  logic [MAX_PATTERN_BYTES-1:0]  tail_hits;
  logic                          take;
  logic                          seen_sel;
  logic [mbps_pkg::OFFSET_W-1:0] off_sel;
  logic [31:0]                   addr_sum;

  assign advance   = ~out_valid_q | out_ch.ready;
  assign in_ch.ready = advance;
  assign in_acc    = in_ch.valid & advance;
  assign scan_acc  = in_acc & (in_ch.command == mbps_pkg::CMD_SCAN);
  assign load_acc  = in_acc & (in_ch.command == mbps_pkg::CMD_LOAD);

  // register writes; length is kept as the index of the last compared cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tail        <= '0;
      use_mask    <= 1'b0;
      find_last   <= 1'b0;
      window_base <= '0;
    end else if (cfg_write) begin
      unique case (mbps_pkg::reg_index_t'(cfg_index))
        mbps_pkg::REG_PATTERN_LENGTH: begin
          if (cfg_data[7:0] == 8'd0) begin
            tail <= '0;
          end else if (32'(cfg_data[7:0]) > 32'(MAX_PATTERN_BYTES)) begin
            tail <= IDX_W'(MAX_PATTERN_BYTES - 1);
          end else begin
            tail <= IDX_W'(cfg_data[7:0] - 8'd1);
          end
        end
        mbps_pkg::REG_USE_MASK:    use_mask    <= cfg_data[0];
        mbps_pkg::REG_FIND_LAST:   find_last   <= cfg_data[0];
        mbps_pkg::REG_WINDOW_BASE: window_base <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign ctrl.scan       = scan_acc;
  assign ctrl.window_end = in_ch.last_byte;
  assign ctrl.use_mask   = use_mask;
  assign ctrl.data_byte  = in_ch.data_byte;

  genvar j;
  generate
    for (j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
      logic chain_in;
      if (j == 0) begin : g_head
        assign chain_in = 1'b0;
      end else begin : g_body
        assign chain_in = chain[j-1];
      end
      mbps_cell #(
        .FIRST (j == 0)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .ctrl          (ctrl),
        .write_en      (load_acc && (32'(in_ch.entry_index) == 32'(j))),
        .pattern_value (in_ch.pattern_value),
        .mask_value    (in_ch.mask_value),
        .enabled       (32'(tail) >= 32'(j)),
        .is_tail       (32'(tail) == 32'(j)),
        .chain_in      (chain_in),
        .chain_out     (chain[j]),
        .tail_hit      (tail_hits[j])
      );
    end
  endgenerate

  // cell stage: full-match flag and the start offset of that alignment
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      st_valid      <= 1'b0;
    end else begin
      if (scan_acc) begin
        byte_position <= in_ch.last_byte ? '0 : byte_position + 1'b1;
      end
      if (advance) begin
        st_valid <= scan_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st_last  <= in_ch.last_byte;
      st_hit   <= |tail_hits;
      st_start <= byte_position - mbps_pkg::OFFSET_W'(tail);
    end
  end

  // match selection
  assign take     = st_hit & (~seen | find_last);
  assign off_sel  = take ? st_start : offset;
  assign seen_sel = seen | st_hit;
  assign addr_sum = (window_base + off_sel) & ADDR_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen        <= 1'b0;
      offset      <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= st_valid & st_last;
      if (st_valid) begin
        if (st_last) begin
          seen   <= 1'b0;
          offset <= '0;
        end else begin
          seen   <= seen_sel;
          offset <= off_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && st_valid && st_last) begin
      out_found_q <= seen_sel;
      out_addr_q  <= seen_sel ? addr_sum : 32'd0;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.found         = out_found_q;
  assign out_ch.match_address = out_addr_q;

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid_q) |-> $past(st_valid && st_last))
    else $error("result without a final window byte");

  a_no_address_unfound: assert property (@(posedge clk) disable iff (rst)
    (out_valid_q && !out_found_q) |-> (out_addr_q == 32'd0))
    else $error("address given for a window without match");

  a_position_restarts: assert property (@(posedge clk) disable iff (rst)
    (scan_acc && in_ch.last_byte) |=> (byte_position == '0))
    else $error("byte position not cleared at window end");

  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (rst)
    !advance |-> out_valid_q)
    else $error("input stalled with no result waiting");

endmodule

FILE: hdl/mbps_cell.sv
// one cell of the alignment chain: a pattern entry, its mask and an alive bit
module mbps_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  mbps_pkg::cell_ctrl_t ctrl,
  input  logic               write_en,
  input  logic [7:0]         pattern_value,
  input  logic [7:0]         mask_value,
  input  logic               enabled,
  input  logic               is_tail,
  input  logic               chain_in,
  output logic               chain_out,
  output logic               tail_hit
);

  logic [7:0] pattern;
  logic [7:0] mask;
  logic       alive;
  logic       prev;
  logic       byte_match;
  logic       hit;

  always_ff @(posedge clk) begin
    if (write_en) begin
      pattern <= pattern_value;
      mask    <= mask_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else if (ctrl.scan) begin
      alive <= ctrl.window_end ? 1'b0 : chain_in;
    end
  end

  // the first cell starts a new alignment on every byte
  assign prev = FIRST ? 1'b1 : alive;

  always_comb begin
    if (ctrl.use_mask) begin
      byte_match = ((ctrl.data_byte ^ pattern) & mask) == 8'h00;
    end else begin
      byte_match = ctrl.data_byte == pattern;
    end
  end

  assign hit       = enabled & prev & byte_match;
  assign chain_out = hit & ~is_tail;
  assign tail_hit  = hit & is_tail;

endmodule
